/* hdl/tcct_pkg.sv */
// tcct_pkg: payload structs and widths for the triangle/circle collision test
// used by the top level, the checker and the bench; no dependencies
`default_nettype none
package tcct_pkg;
  localparam int unsigned CW = 16;

  typedef struct packed {
    logic signed [CW-1:0] v0_x;
    logic signed [CW-1:0] v0_y;
    logic signed [CW-1:0] v1_x;
    logic signed [CW-1:0] v1_y;
    logic signed [CW-1:0] v2_x;
    logic signed [CW-1:0] v2_y;
    logic signed [CW-1:0] circle_x;
    logic signed [CW-1:0] circle_y;
    logic        [CW-2:0] circle_radius;
  } tcct_in_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] edge_mask;
    logic       center_inside;
  } tcct_out_t;
endpackage
`default_nettype wire

/* hdl/triangle_circle_collision_test_unit.sv */
// triangle_circle_collision_test_unit: top level of the collision test
// depends on tcct_pkg and tcct_edge
`default_nettype none
// usage:
//   drive in_i and pulse start_i; a beat is taken at any edge with start_i high
//   and busy_o low. busy_o is always low, so one beat can enter every cycle.
//   stage 0 registers the centered deltas, three stages run the root test of
//   each edge in its own tcct_edge, side tests run alongside in step.
//   each result appears on out_o for one cycle with done_o high;
//   throughput is one beat per cycle.
//   the receiver cannot stall: results are never held.
//   reset clears the valid bits only; data registers are not reset.
//   the block keeps no state between items.
module triangle_circle_collision_test_unit
  import tcct_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire tcct_in_t in_i,
  output logic          busy_o,
  output logic          done_o,
  output tcct_out_t     out_o
);
  localparam int unsigned W = CW + 1;
  logic [3:0] vld_q;
  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], start_i};
    end
  end

  // stage 0: deltas
  logic signed [W-1:0] sx_q [3], sy_q [3], ex_q [3], ey_q [3];
  logic [2*CW-3:0] r2_q;
  logic signed [CW-1:0] px [3], py [3];
  always_comb begin
    px[0] = in_i.v0_x; py[0] = in_i.v0_y;
    px[1] = in_i.v1_x; py[1] = in_i.v1_y;
    px[2] = in_i.v2_x; py[2] = in_i.v2_y;
  end
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sx_q[i] <= W'(px[i]) - W'(in_i.circle_x);
      sy_q[i] <= W'(py[i]) - W'(in_i.circle_y);
      ex_q[i] <= W'(px[(i+1)%3]) - W'(px[i]);
      ey_q[i] <= W'(py[(i+1)%3]) - W'(py[i]);
    end
    r2_q <= (2*CW-2)'(in_i.circle_radius * in_i.circle_radius);
  end

  logic [2:0] cross_w;
  for (genvar g = 0; g < 3; g++) begin : g_edge
    tcct_edge #(.CW(CW)) u_edge (
      .clk_i, .sx_i(sx_q[g]), .sy_i(sy_q[g]), .ex_i(ex_q[g]), .ey_i(ey_q[g]),
      .r2_i(r2_q), .cross_o(cross_w[g])
    );
  end

  // side test: cross = ex*(-sy) - ey*(-sx) = ey*sx - ex*sy
  logic signed [2*W-1:0] l_q [3], r_q [3];
  logic [2:0] s_q, s2_q;
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      l_q[i] <= (2*W)'(ey_q[i]*sx_q[i]);
      r_q[i] <= (2*W)'(ex_q[i]*sy_q[i]);
      s_q[i] <= l_q[i] > r_q[i];
    end
    s2_q <= s_q;
  end

  logic inside_w;
  assign inside_w = (s2_q[0] == s2_q[1]) && (s2_q[1] == s2_q[2]);
  assign done_o = vld_q[3];
  always_comb begin
    out_o.edge_mask     = cross_w;
    out_o.center_inside = inside_w;
    out_o.hit           = (cross_w != 3'b000) || inside_w;
  end
endmodule
`default_nettype wire

/* hdl/tcct_edge.sv */
// tcct_edge: pipelined quadratic root test for one triangle edge
// depends on nothing; there is no valid bit, stages advance every clock
`default_nettype none
module tcct_edge #(
  parameter int unsigned CW = 16
) (
  input  wire logic                 clk_i,
  input  wire logic signed [CW:0]   sx_i,
  input  wire logic signed [CW:0]   sy_i,
  input  wire logic signed [CW:0]   ex_i,
  input  wire logic signed [CW:0]   ey_i,
  input  wire logic        [2*CW-3:0] r2_i,
  output logic                      cross_o
);
  localparam int unsigned PW = 2*CW + 4;  // a, b, c
  localparam int unsigned DW = 4*CW + 12; // d

  // stage 1: products
  logic signed [PW-1:0] a_d, b_d, c_d, a_q, b_q, c_q;
  always_comb begin
    a_d = PW'(ex_i*ex_i) + PW'(ey_i*ey_i);
    b_d = (PW'(sx_i*ex_i) + PW'(sy_i*ey_i)) <<< 1;
    c_d = PW'(sx_i*sx_i) + PW'(sy_i*sy_i) - PW'($signed({1'b0, r2_i}));
  end
  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    c_q <= c_d;
  end

  // stage 2: b^2 and 4ac, plus side sums
  logic signed [DW-1:0] bb_q, ac_q;
  logic bneg_q, cneg_q, cpos_q, gpos_q, f1pos_q, f1neg_q;
  logic signed [PW+1:0] g_w, f1_w;
  always_comb begin
    g_w  = (PW+2)'(a_q) + (PW+2)'(a_q) + (PW+2)'(b_q);
    f1_w = (PW+2)'(a_q) + (PW+2)'(b_q) + (PW+2)'(c_q);
  end
  always_ff @(posedge clk_i) begin
    bb_q    <= DW'(b_q*b_q);
    ac_q    <= DW'(a_q*c_q) <<< 2;
    bneg_q  <= b_q < 0;
    cneg_q  <= c_q < 0;
    cpos_q  <= c_q > 0;
    gpos_q  <= g_w > 0;
    f1pos_q <= f1_w > 0;
    f1neg_q <= f1_w < 0;
  end

  // stage 3: discriminant sign and root windows
  logic rhi, rlo;
  always_comb begin
    rhi = (bneg_q || cneg_q) && gpos_q && f1pos_q;
    rlo = bneg_q && cpos_q && (gpos_q || f1neg_q);
  end
  always_ff @(posedge clk_i) begin
    cross_o <= (bb_q > ac_q) && (rhi || rlo);
  end
endmodule
`default_nettype wire

/* hdl/tcct_checker.sv */
// tcct_checker: port-level assertions for the collision test unit
// depends on tcct_pkg; bound to triangle_circle_collision_test_unit
`default_nettype none
module tcct_checker
  import tcct_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      start_i,
  input wire logic      busy_o,
  input wire logic      done_o,
  input wire tcct_out_t out_o
);
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##4 done_o) else $error("missing result");
  a_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (out_o.hit == ((out_o.edge_mask != 3'b000) || out_o.center_inside)))
    else $error("hit mismatch");
  a_nobusy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");
endmodule

bind triangle_circle_collision_test_unit tcct_checker u_tcct_checker (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .out_o
);
`default_nettype wire

/* verif/tb_triangle_circle_collision_test_unit.sv */
// tb_triangle_circle_collision_test_unit: self-checking bench for the collision test
// depends on tcct_pkg and triangle_circle_collision_test_unit
module tb_triangle_circle_collision_test_unit;
  import tcct_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 4;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start_i = 1'b0;
  tcct_in_t  in_i = '0;
  logic      busy_o;
  logic      done_o;
  tcct_out_t out_o;

  tcct_out_t expected_hits[$];
  int        error_count = 0;

  triangle_circle_collision_test_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .in_i(in_i),
    .busy_o(busy_o), .done_o(done_o), .out_o(out_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    error_count++;
  endtask

  // exact root test on edge p->q with the centre at the origin
  function automatic bit edge_crosses(longint px, longint py, longint qx, longint qy,
                                      longint r2);
    logic signed [127:0] ex, ey, a, b, c, d, g, f1;
    bit bneg, cneg, cpos, gpos, f1pos, f1neg;
    ex = qx - px;
    ey = qy - py;
    a = ex * ex + ey * ey;
    b = 2 * (px * ex + py * ey);
    c = px * px + py * py - r2;
    d = b * b - 4 * a * c;
    if (d <= 0) return 1'b0;
    g = 2 * a + b;
    f1 = a + b + c;
    bneg = b < 0;
    cneg = c < 0;
    cpos = c > 0;
    gpos = g > 0;
    f1pos = f1 > 0;
    f1neg = f1 < 0;
    return ((bneg || cneg) && gpos && f1pos) || (bneg && cpos && (gpos || f1neg));
  endfunction

  function automatic bit left_of(longint px, longint py, longint qx, longint qy,
                                 longint tx, longint ty);
    return ((qx - px) * (ty - py) - (qy - py) * (tx - px)) > 0;
  endfunction

  function automatic tcct_out_t predict_collision(tcct_in_t t);
    tcct_out_t o;
    longint x0, y0, x1, y1, x2, y2, cx, cy, r2;
    bit s1, s2, s3;
    x0 = t.v0_x; y0 = t.v0_y; x1 = t.v1_x; y1 = t.v1_y;
    x2 = t.v2_x; y2 = t.v2_y; cx = t.circle_x; cy = t.circle_y;
    r2 = longint'(t.circle_radius) * longint'(t.circle_radius);
    o.edge_mask[0] = edge_crosses(x0 - cx, y0 - cy, x1 - cx, y1 - cy, r2);
    o.edge_mask[1] = edge_crosses(x1 - cx, y1 - cy, x2 - cx, y2 - cy, r2);
    o.edge_mask[2] = edge_crosses(x2 - cx, y2 - cy, x0 - cx, y0 - cy, r2);
    s1 = left_of(x0, y0, x1, y1, cx, cy);
    s2 = left_of(x1, y1, x2, y2, cx, cy);
    s3 = left_of(x2, y2, x0, y0, cx, cy);
    o.center_inside = (s1 == s2) && (s2 == s3);
    o.hit = (o.edge_mask != 3'd0) || o.center_inside;
    return o;
  endfunction

  // sends one beat; start stays high across back-to-back beats
  task automatic send_beat(input tcct_in_t t);
    int gap;
    gap = $urandom_range(0, 6);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i <= t;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    expected_hits.insert(expected_hits.size(), predict_collision(t));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        tcct_out_t e;
        e = expected_hits.pop_front();
        if (out_o.hit !== e.hit)
          report_mismatch($sformatf("hit %b exp %b", out_o.hit, e.hit));
        if (out_o.edge_mask !== e.edge_mask)
          report_mismatch($sformatf("edge_mask %b exp %b", out_o.edge_mask, e.edge_mask));
        if (out_o.center_inside !== e.center_inside)
          report_mismatch($sformatf("center_inside %b exp %b",
                                    out_o.center_inside, e.center_inside));
      end
    end
  end

  function automatic tcct_in_t make_tri(int x0, int y0, int x1, int y1, int x2, int y2,
                                        int cx, int cy, int r);
    tcct_in_t t;
    t.v0_x = CW'(x0); t.v0_y = CW'(y0); t.v1_x = CW'(x1); t.v1_y = CW'(y1);
    t.v2_x = CW'(x2); t.v2_y = CW'(y2); t.circle_x = CW'(cx); t.circle_y = CW'(cy);
    t.circle_radius = (CW-1)'(r);
    return t;
  endfunction

  task automatic test_directed();
    send_beat(make_tri(0, 0, 160, 0, 0, 160, 40, 40, 16));           // centre inside
    send_beat(make_tri(0, 0, 160, 0, 0, 160, 80, -10, 32));          // crosses one edge
    send_beat(make_tri(0, 0, 160, 0, 0, 160, 80, -32, 32));          // tangent edge
    send_beat(make_tri(50, 50, 50, 50, 200, 0, 50, 50, 20));         // zero-length edge
    send_beat(make_tri(-16, 0, 16, 0, 0, 64, 0, 0, 16));             // roots at the ends
    send_beat(make_tri(0, 0, 16, 0, 0, 16, 0, 0, 32767));            // circle covers all
    send_beat(make_tri(0, 0, 32, 32, 64, 64, 500, 7, 3));            // degenerate triangle
    send_beat(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_beat(make_tri(-32768, -32768, 32767, -32768, 0, 32767, 0, 0, 32767));
    send_beat(make_tri(32767, 32767, -32768, 32767, 32767, -32768, -32768, -32768, 32767));
    send_beat(make_tri(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767, 0));
    send_beat(make_tri(0, 0, 160, 0, 0, 160, 1000, 1000, 10));       // miss, outside
    send_beat(make_tri(0, 0, 0, 160, 160, 0, 40, 40, 16));           // clockwise order
    send_beat('1);
  endtask

  task automatic test_random(input int count);
    tcct_in_t t;
    int span, cx, cy;
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) begin
        t = tcct_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
      end else begin
        // local triangle near the circle so edges and sides are exercised
        span = 1 << $urandom_range(2, 14);
        cx = $urandom_range(0, 65535) - 32768;
        cy = $urandom_range(0, 65535) - 32768;
        t.circle_x = CW'(cx);
        t.circle_y = CW'(cy);
        t.v0_x = CW'(cx + $urandom_range(0, 2 * span) - span);
        t.v0_y = CW'(cy + $urandom_range(0, 2 * span) - span);
        t.v1_x = CW'(cx + $urandom_range(0, 2 * span) - span);
        t.v1_y = CW'(cy + $urandom_range(0, 2 * span) - span);
        t.v2_x = CW'(cx + $urandom_range(0, 2 * span) - span);
        t.v2_y = CW'(cy + $urandom_range(0, 2 * span) - span);
        t.circle_radius = (CW-1)'($urandom_range(0, span));
      end
      send_beat(t);
    end
  endtask

  task automatic test_drain_pause();
    start_i <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_drain_pause();
    test_random(750);
    test_drain_pause();
    test_random(750);
    start_i <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
